>>> rtl/knup_pkg.sv
// ----------------------------------------------------------------------------
// knup_pkg
// Shared types and codes of the nearest unused point selector.
// ----------------------------------------------------------------------------
package knup_pkg;

  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_K_NEAR = 2'd1,
    KIND_NEAR   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctl_t;

  localparam int OUT_IDX_W  = 6;
  localparam int OUT_DIST_W = 50;

endpackage

>>> rtl/knup_ram.sv
// ----------------------------------------------------------------------------
// knup_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module knup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> rtl/knup_dist.sv
// ----------------------------------------------------------------------------
// knup_dist
// Three-stage squared distance unit: difference, square, sum.
// ----------------------------------------------------------------------------
module knup_dist #(
  parameter int CB = 24,
  parameter int AW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_v,
  input  logic [AW-1:0]       in_idx,
  input  logic [CB-1:0]       px,
  input  logic [CB-1:0]       py,
  input  logic [CB-1:0]       pz,
  input  logic                p_used,
  input  logic                skip_used,
  input  logic [CB-1:0]       qx,
  input  logic [CB-1:0]       qy,
  input  logic [CB-1:0]       qz,
  output logic                cand_v,
  output logic [AW-1:0]       cand_idx,
  output logic [2*CB+1:0]     cand_dist
);

  localparam int DW = 2 * CB + 2;

  logic                 a_v_r, b_v_r;
  logic [AW-1:0]        a_idx_r, b_idx_r;
  logic signed [CB:0]   dx_r, dy_r, dz_r;
  logic [DW-1:0]        sx_r, sy_r, sz_r;
  logic signed [DW-1:0] mx, my, mz;

  assign mx = dx_r * dx_r;
  assign my = dy_r * dy_r;
  assign mz = dz_r * dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      cand_v <= 1'b0;
    end else begin
      a_v_r  <= in_v && !(skip_used && p_used);
      b_v_r  <= a_v_r;
      cand_v <= b_v_r;
    end
    dx_r      <= $signed({px[CB-1], px}) - $signed({qx[CB-1], qx});
    dy_r      <= $signed({py[CB-1], py}) - $signed({qy[CB-1], qy});
    dz_r      <= $signed({pz[CB-1], pz}) - $signed({qz[CB-1], qz});
    a_idx_r   <= in_idx;
    sx_r      <= DW'(mx);
    sy_r      <= DW'(my);
    sz_r      <= DW'(mz);
    b_idx_r   <= a_idx_r;
    cand_dist <= sx_r + sy_r + sz_r;
    cand_idx  <= b_idx_r;
  end

endmodule

>>> rtl/knup_cell.sv
// ----------------------------------------------------------------------------
// knup_cell
// One slot of the sorted candidate chain: insert in order, shift out.
// ----------------------------------------------------------------------------
module knup_cell #(
  parameter int DW = 50,
  parameter int AW = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  knup_pkg::cell_ctl_t   ctl,
  input  logic [DW-1:0]         cand_dist,
  input  logic [AW-1:0]         cand_idx,
  input  logic                  prev_ins,
  input  logic                  prev_v,
  input  logic [DW-1:0]         prev_dist,
  input  logic [AW-1:0]         prev_idx,
  input  logic                  next_v,
  input  logic [DW-1:0]         next_dist,
  input  logic [AW-1:0]         next_idx,
  output logic                  ins,
  output logic                  v_r,
  output logic [DW-1:0]         dist_r,
  output logic [AW-1:0]         idx_r
);

  import knup_pkg::*;

  assign ins = ctl.insert && (!v_r || (cand_dist < dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ctl.clear) begin
      v_r <= 1'b0;
    end else if (ctl.shift) begin
      v_r <= next_v;
    end else if (ins) begin
      v_r <= prev_ins ? prev_v : 1'b1;
    end
    if (ctl.shift) begin
      dist_r <= next_dist;
      idx_r  <= next_idx;
    end else if (ins) begin
      dist_r <= prev_ins ? prev_dist : cand_dist;
      idx_r  <= prev_ins ? prev_idx : cand_idx;
    end
  end

endmodule

>>> rtl/k_nearest_unused_point_select_top.sv
// ----------------------------------------------------------------------------
// k_nearest_unused_point_select_top
// Point table with k nearest unused and nearest any queries.
// ----------------------------------------------------------------------------
// Usage: drive an item with start while busy is low. A write item (kind 0)
// stores one entry and keeps busy low. A query (kind 1 or 2) raises busy,
// reads entries 0..min(point_count, TABLE_DEPTH)-1 one per cycle through the
// RAM read port and a three-stage distance unit, and inserts each candidate
// into a sorted chain of MAX_PICK cells. After the scan and the drain the
// chain shifts out one result beat per cycle on out_strobe, the final one
// with out_last. A query with point_count 0 skips the scan and the drain;
// the table read port sets the scan at one entry per cycle.
// If no entry qualifies, one beat with out_found low follows.
// Results cannot be held off; each beat is on the ports for one cycle.
// cfg_data sets point_count whenever cfg_valid is high (cfg_ready is always
// high); write it only while idle. Reset clears point_count and control
// state; table contents are undefined until written.
// ----------------------------------------------------------------------------
module k_nearest_unused_point_select_top #(
  parameter int TABLE_DEPTH = 64,
  parameter int MAX_PICK    = 16,
  parameter int COORD_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_entry_index,
  input  logic [23:0] in_coord_x,
  input  logic [23:0] in_coord_y,
  input  logic [23:0] in_coord_z,
  input  logic        in_used_flag,
  input  logic [4:0]  in_pick_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output logic        out_strobe,
  output logic [5:0]  out_point_index,
  output logic        out_found,
  output logic [49:0] out_distance_sq,
  output logic        out_last
);

  import knup_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = $clog2(MAX_PICK + 1);
  localparam int DW = 2 * CB + 2;
  localparam int RW = 3 * CB + 1;

  state_t          state_r, state_nxt;
  logic [6:0]      pcount_r;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   scan_r, scan_nxt;
  logic [1:0]      drain_r, drain_nxt;
  logic [PW-1:0]   req_r, req_nxt;
  logic [PW-1:0]   emit_r, emit_nxt;
  logic            skip_r;
  logic [CB-1:0]   qx_r, qy_r, qz_r;
  logic            rd_v_r;
  logic [AW-1:0]   rd_idx_r;
  logic            accept, is_query, wr_en;
  logic [AW+5:0]   eidx_wide;
  logic [CW+6:0]   pc_wide;
  logic [RW-1:0]   rdata;
  logic            cand_v;
  logic [AW-1:0]   cand_idx;
  logic [DW-1:0]   cand_dist;
  logic            last_beat;
  logic [AW+5:0]   oidx_wide;
  cell_ctl_t       ctl;

  logic            cv   [MAX_PICK+1];
  logic [DW-1:0]   cd   [MAX_PICK+1];
  logic [AW-1:0]   cix  [MAX_PICK+1];
  logic            cins [MAX_PICK+1];

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign is_query  = (in_kind == KIND_K_NEAR) || (in_kind == KIND_NEAR);
  assign eidx_wide = (AW + 6)'(in_entry_index);
  assign wr_en     = accept && (in_kind == KIND_WRITE) &&
                     (32'(in_entry_index) < TABLE_DEPTH);
  assign pc_wide   = (CW + 7)'(pcount_r);

  knup_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (eidx_wide[AW-1:0]),
    .wdata ({in_used_flag, in_coord_z[CB-1:0], in_coord_y[CB-1:0], in_coord_x[CB-1:0]}),
    .raddr (scan_r[AW-1:0]),
    .rdata (rdata)
  );

  knup_dist #(.CB(CB), .AW(AW)) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (rd_v_r),
    .in_idx    (rd_idx_r),
    .px        (rdata[CB-1:0]),
    .py        (rdata[2*CB-1:CB]),
    .pz        (rdata[3*CB-1:2*CB]),
    .p_used    (rdata[3*CB]),
    .skip_used (skip_r),
    .qx        (qx_r),
    .qy        (qy_r),
    .qz        (qz_r),
    .cand_v    (cand_v),
    .cand_idx  (cand_idx),
    .cand_dist (cand_dist)
  );

  assign ctl.clear  = accept && is_query;
  assign ctl.insert = cand_v;
  assign ctl.shift  = (state_r == ST_EMIT);

  assign cins[0]        = 1'b0;
  assign cv[MAX_PICK]   = 1'b0;
  assign cd[MAX_PICK]   = '0;
  assign cix[MAX_PICK]  = '0;

  for (genvar j = 0; j < MAX_PICK; j++) begin : g_cell
    logic          p_v;
    logic [DW-1:0] p_d;
    logic [AW-1:0] p_i;
    if (j == 0) begin : g_first
      assign p_v = 1'b0;
      assign p_d = '0;
      assign p_i = '0;
    end else begin : g_rest
      assign p_v = cv[j-1];
      assign p_d = cd[j-1];
      assign p_i = cix[j-1];
    end
    knup_cell #(.DW(DW), .AW(AW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cand_dist (cand_dist),
      .cand_idx  (cand_idx),
      .prev_ins  (cins[j]),
      .prev_v    (p_v),
      .prev_dist (p_d),
      .prev_idx  (p_i),
      .next_v    (cv[j+1]),
      .next_dist (cd[j+1]),
      .next_idx  (cix[j+1]),
      .ins       (cins[j+1]),
      .v_r       (cv[j]),
      .dist_r    (cd[j]),
      .idx_r     (cix[j])
    );
  end

  assign last_beat = !cv[0] || !cv[1] || (emit_r == req_r - PW'(1));
  assign oidx_wide = (AW + 6)'(cix[0]);

  assign out_strobe      = (state_r == ST_EMIT);
  assign out_found       = cv[0];
  assign out_point_index = cv[0] ? oidx_wide[5:0] : '0;
  assign out_distance_sq = cv[0] ? OUT_DIST_W'(cd[0]) : '0;
  assign out_last        = last_beat;

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    scan_nxt  = scan_r;
    drain_nxt = drain_r;
    req_nxt   = req_r;
    emit_nxt  = emit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_query) begin
          if (32'(pcount_r) > TABLE_DEPTH) begin
            n_nxt = CW'(TABLE_DEPTH);
          end else begin
            n_nxt = pc_wide[CW-1:0];
          end
          if (in_kind == KIND_NEAR || in_pick_count == 5'd0) begin
            req_nxt = PW'(1);
          end else if (32'(in_pick_count) > MAX_PICK) begin
            req_nxt = PW'(MAX_PICK);
          end else begin
            req_nxt = PW'(in_pick_count);
          end
          scan_nxt  = '0;
          emit_nxt  = '0;
          state_nxt = (pcount_r == 7'd0) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_nxt = scan_r + CW'(1);
        if (scan_r == n_r - CW'(1)) begin
          drain_nxt = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 2'd1;
        if (drain_r == 2'd3) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        emit_nxt = emit_r + PW'(1);
        if (last_beat) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pcount_r <= '0;
      rd_v_r   <= 1'b0;
      scan_r   <= '0;
      drain_r  <= '0;
      emit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        pcount_r <= cfg_data;
      end
      rd_v_r  <= (state_r == ST_SCAN);
      scan_r  <= scan_nxt;
      drain_r <= drain_nxt;
      emit_r  <= emit_nxt;
    end
    n_r      <= n_nxt;
    req_r    <= req_nxt;
    rd_idx_r <= scan_r[AW-1:0];
    if (accept && is_query) begin
      skip_r <= (in_kind == KIND_K_NEAR);
      qx_r   <= in_coord_x[CB-1:0];
      qy_r   <= in_coord_y[CB-1:0];
      qz_r   <= in_coord_z[CB-1:0];
    end
  end

endmodule
